### rtl/ais_pkg.sv
package ais_pkg;

   localparam int KEY_W = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TEST,
      ST_EMIT_READ,
      ST_EMIT_WAIT
   } ais_state_type;

   typedef struct packed {
      logic load;   // take the accepted key into the hold register
      logic fetch;  // read the entry below the open slot
      logic shift;  // move the larger entry up into the open slot
      logic place;  // drop the held key into the open slot
      logic emit;   // load the output register from the read data
   } ais_cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic greater;
      logic batch_done;
      logic emit_last;
      logic out_free;
   } ais_status_type;

endpackage

### rtl/ais_req_if.sv
interface ais_req_if import ais_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_value;
   logic             batch_end;

   modport source (output valid, output key_value, output batch_end, input ready);
   modport sink   (input valid, input key_value, input batch_end, output ready);
   modport mon    (input valid, input key_value, input batch_end, input ready);
endinterface

### rtl/ais_rsp_if.sv
interface ais_rsp_if import ais_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic             final_key;

   modport source (output valid, output sorted_key, output final_key, input ready);
   modport sink   (input valid, input sorted_key, input final_key, output ready);
   modport mon    (input valid, input sorted_key, input final_key, input ready);
endinterface

### rtl/ais_ctrl.sv
module ais_ctrl import ais_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_end,
   output logic           req_ready,
   input  ais_status_type status,
   output ais_cmd_type    cmd
);

   ais_state_type state_ff;
   ais_state_type state_in;
   logic          req_fire;

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!status.full) begin
                  state_in = ST_FETCH;
               end else if (req_end) begin
                  state_in = ST_EMIT_READ;
               end
            end
         end
         ST_FETCH: begin
            if (status.pos_zero) begin
               state_in = status.batch_done ? ST_EMIT_READ : ST_IDLE;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.greater) begin
               state_in = ST_FETCH;
            end else begin
               state_in = status.batch_done ? ST_EMIT_READ : ST_IDLE;
            end
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (status.out_free) begin
               state_in = status.emit_last ? ST_IDLE : ST_EMIT_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_FETCH: begin
            cmd.place = status.pos_zero;
            cmd.fetch = !status.pos_zero;
         end
         ST_TEST: begin
            cmd.shift = status.greater;
            cmd.place = !status.greater;
         end
         ST_EMIT_READ: begin
         end
         ST_EMIT_WAIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/ais_dpath.sv
module ais_dpath import ais_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  ais_cmd_type      cmd,
   output ais_status_type   status,
   input  logic [KEY_W-1:0] req_key,
   input  logic             req_end,
   output logic [KEY_W-1:0] rsp_key,
   output logic             rsp_final,
   output logic             rsp_valid,
   input  logic             rsp_ready
);

   localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEYS);

   logic [KEY_W-1:0] mem [MAX_KEYS];
   logic [KEY_W-1:0] rd_data_ff;
   logic [KEY_W-1:0] hold_ff;
   logic [IW-1:0]    pos_ff;
   logic [IW-1:0]    pos_in;
   logic [IW-1:0]    idx_ff;
   logic [IW-1:0]    idx_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             last_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic             rsp_final_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [KEY_W-1:0] wr_data;
   logic             full;
   logic             emit_last;

   assign full      = (count_ff == FULL_COUNT);
   assign emit_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign rd_addr   = cmd.fetch ? (pos_ff - IW'(1)) : idx_ff;
   assign wr_en     = cmd.shift || cmd.place;
   assign wr_data   = cmd.shift ? rd_data_ff : hold_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Insertion opens a slot at the end of the batch and walks it down.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_ff <= req_end;
         if (!full) begin
            hold_ff <= req_key;
         end
      end
      if (cmd.emit) begin
         rsp_key_ff   <= rd_data_ff;
         rsp_final_ff <= emit_last;
      end
      pos_ff <= pos_in;
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load && !full) begin
         pos_in = count_ff[IW-1:0];
      end else if (cmd.shift) begin
         pos_in = pos_ff - IW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.load && !full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.emit) begin
         if (emit_last) begin
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.full       = full;
   assign status.pos_zero   = (pos_ff == '0);
   assign status.greater    = (rd_data_ff > hold_ff);
   assign status.batch_done = last_ff;
   assign status.emit_last  = emit_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_key   = rsp_key_ff;
   assign rsp_final = rsp_final_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/ascending_insertion_sorter.sv
// Ascending insertion sorter: keys arrive one per transfer into a batch of up to MAX_KEYS
// entries; each stored key is inserted in place at once by walking an open slot down the
// key memory, one read then one compare/write per step, and the input is not ready during
// that walk. Keys past MAX_KEYS are dropped. A transfer with batch_end closes the batch and
// the keys are sent smallest first, equal keys in arrival order, each read through the
// registered memory read port and then loaded into the output register when it is free,
// final_key set on the last. The output register lets the next batch start loading while
// the last key of the previous one still waits.
module ascending_insertion_sorter import ais_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic      clock,
   input  logic      reset,
   ais_req_if.sink   req_if,
   ais_rsp_if.source rsp_if
);

   ais_cmd_type    cmd;
   ais_status_type status;

   ais_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_end   (req_if.batch_end),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ais_dpath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_key   (req_if.key_value),
      .req_end   (req_if.batch_end),
      .rsp_key   (rsp_if.sorted_key),
      .rsp_final (rsp_if.final_key),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready)
   );

endmodule

### rtl/ais_checker.sv
module ais_checker import ais_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_batch_end,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [KEY_W-1:0] rsp_sorted_key,
   input logic             rsp_final_key
);

   logic [KEY_W-1:0] prev_key_ff;
   logic             in_run_ff;
   logic [1:0]       pend_ff;
   logic [1:0]       pend_in;
   logic             end_xfer;
   logic             final_xfer;

   assign end_xfer   = req_valid && req_ready && req_batch_end;
   assign final_xfer = rsp_valid && rsp_ready && rsp_final_key;

   always_comb begin
      pend_in = pend_ff;
      if (end_xfer && !final_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (!end_xfer && final_xfer && pend_ff != 2'd0) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         pend_ff <= pend_in;
         if (rsp_valid && rsp_ready) begin
            in_run_ff <= !rsp_final_key;
         end
      end
      if (rsp_valid && rsp_ready) begin
         prev_key_ff <= rsp_sorted_key;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sorted_key) && $stable(rsp_final_key))
      else $error("result changed while stalled");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && in_run_ff |-> rsp_sorted_key >= prev_key_ff)
      else $error("results out of ascending order");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a closed batch");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ascending_insertion_sorter ais_checker u_ais_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_batch_end  (req_if.batch_end),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_sorted_key (rsp_if.sorted_key),
   .rsp_final_key  (rsp_if.final_key)
);

### tb/tb_ascending_insertion_sorter.sv
`timescale 1ns / 100ps

module tb_ascending_insertion_sorter;
   import ais_pkg::*;

   localparam int MAX_KEYS       = 64;
   localparam int ITEM_TARGET    = 380;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic             last;
      bit               drain;  // hold off until every sorted key has come back
   } key_item_type;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic             final_flag;
   } key_result_type;

   logic clock;
   logic reset;

   ais_req_if req_bus ();
   ais_rsp_if rsp_bus ();

   key_item_type     pending_keys[$];
   logic [KEY_W-1:0] batch_keys[$];
   key_result_type   sorted_expect[$];
   int unsigned      accepted_keys = 0;
   int unsigned      mismatches = 0;
   int unsigned      stall_cycles = 0;
   int unsigned      stimulus_count = 0;

   ascending_insertion_sorter #(.MAX_KEYS(MAX_KEYS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // both sides run without gaps over a stretch of the stimulus
   function automatic bit quiet_window();
      return accepted_keys >= 160 && accepted_keys < 240;
   endfunction

   // store the key; on the end mark sort the held batch and queue its keys
   function automatic void absorb_key(logic [KEY_W-1:0] key, logic last);
      logic [KEY_W-1:0] run[$];
      logic [KEY_W-1:0] hold;
      int               pos;
      if (batch_keys.size() < MAX_KEYS)
         batch_keys.push_back(key);
      if (!last)
         return;
      run = batch_keys;
      // strict compare keeps equal keys in arrival order
      for (int i = 1; i < run.size(); i++) begin
         hold = run[i];
         pos  = i;
         while (pos > 0 && run[pos-1] > hold) begin
            run[pos] = run[pos-1];
            pos--;
         end
         run[pos] = hold;
      end
      foreach (run[k])
         sorted_expect.push_back(key_result_type'{key: run[k],
                                                  final_flag: (k == run.size() - 1)});
      batch_keys.delete();
   endfunction

   function automatic logic [KEY_W-1:0] random_key(int mode);
      logic [KEY_W-1:0] corners[4];
      corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      case (mode)
         1: return $urandom_range(0, 7);
         2: return corners[$urandom_range(0, 3)];
         3: return {16'($urandom_range(0, 20)), 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   task automatic push_batch(input logic [KEY_W-1:0] keys[$], input bit drain);
      foreach (keys[i]) begin
         pending_keys.push_back(key_item_type'{key: keys[i], last: (i == keys.size() - 1),
                                               drain: drain && (i == 0)});
         stimulus_count++;
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.key_value = '0;
      req_bus.batch_end = 1'b0;
      rsp_bus.ready  = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      logic [KEY_W-1:0] batch[$];
      int               size;
      int               pick;
      int               mode;
      bit               first;

      // directed: single-key batches, corners, reversed input, repeated keys
      batch = '{32'h0000_0000};
      push_batch(batch, 0);
      batch = '{32'hFFFF_FFFF};
      push_batch(batch, 1);
      batch = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
      push_batch(batch, 0);
      batch = '{32'd50, 32'd40, 32'd30, 32'd20, 32'd10};
      push_batch(batch, 0);
      batch = '{32'd3, 32'd3, 32'd3, 32'd9};
      push_batch(batch, 1);

      // random batches; the first one overflows the store
      first = 1;
      while (stimulus_count < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (first)
            size = MAX_KEYS + 2;
         else if (pick < 75)
            size = $urandom_range(1, 8);
         else if (pick < 90)
            size = $urandom_range(9, 24);
         else if (pick < 95)
            size = MAX_KEYS;
         else
            size = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 4);
         pick = $urandom_range(0, 9);
         mode = (pick < 5) ? 0 : pick - 5;
         batch.delete();
         for (int i = 0; i < size; i++)
            batch.push_back(random_key(mode));
         push_batch(batch, first || $urandom_range(0, 9) == 0);
         first = 0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_keys.size() != 0 || req_bus.valid || sorted_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && sorted_expect.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // key driver; prediction happens here on each accepted transfer
   always @(posedge clock) begin
      key_item_type next_item;
      logic         next_valid;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.key_value <= '0;
         req_bus.batch_end <= 1'b0;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            absorb_key(req_bus.key_value, req_bus.batch_end);
            accepted_keys++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_keys.size() != 0
             && (quiet_window() || $urandom_range(0, 99) >= 11)
             && !(pending_keys[0].drain && sorted_expect.size() != 0)) begin
            next_item = pending_keys.pop_front();
            req_bus.key_value <= next_item.key;
            req_bus.batch_end <= next_item.last;
            next_valid = 1'b1;
         end
         req_bus.valid <= next_valid;
      end
   end

   // sorted key monitor
   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sorted_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected sorted key %h final %b", rsp_bus.sorted_key,
                           rsp_bus.final_key);
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_bus.sorted_key !== want.key || rsp_bus.final_key !== want.final_flag) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sorted key mismatch: expected %h final %b, got %h final %b",
                              want.key, want.final_flag, rsp_bus.sorted_key,
                              rsp_bus.final_key);
               end
            end
         end
         rsp_bus.ready <= quiet_window() || $urandom_range(0, 99) >= 11;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

### filelist.f
rtl/ais_pkg.sv
rtl/ais_req_if.sv
rtl/ais_rsp_if.sv
rtl/ais_ctrl.sv
rtl/ais_dpath.sv
rtl/ascending_insertion_sorter.sv
rtl/ais_checker.sv
tb/tb_ascending_insertion_sorter.sv
